@@ src/bpd_pkg.sv @@
// Shared constants, codes and types for the BMP pixel decoder.
`default_nettype none

package bpd_pkg;

   localparam int MAX_WIDTH       = 1024;
   localparam int MAX_HEIGHT      = 1024;
   localparam int PALETTE_ENTRIES = 256;

   localparam int DIM_W   = 11;
   localparam int BYTE_W  = 8;
   localparam int COLOR_W = 3 * BYTE_W;
   localparam int ADDR_W  = 20;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int RUN_W   = $clog2(3 * MAX_WIDTH + 1);
   localparam int LIM_W   = DIM_W + 2;
   localparam int PROD_W  = ROW_W + DIM_W;
   localparam int PAL_IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   localparam int CSR_IDX_W    = 3;
   localparam int IN_TDATA_W   = 40;
   localparam int OUT_TDATA_W  = 48;
   localparam int OUT_PAD_W    = OUT_TDATA_W - COLOR_W - ADDR_W;

   localparam logic [DIM_W-1:0] RST_WIDTH  = 11'd480;
   localparam logic [DIM_W-1:0] RST_HEIGHT = 11'd272;

   localparam logic OP_PALETTE      = 1'b0;
   localparam logic OP_PIXEL        = 1'b1;
   localparam logic DEPTH_8BPP      = 1'b0;
   localparam logic DEPTH_24BPP     = 1'b1;
   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_SIZE_ERR = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EXP_WIDTH  = 3'd0,
      CSR_EXP_HEIGHT = 3'd1,
      CSR_IMG_WIDTH  = 3'd2,
      CSR_IMG_HEIGHT = 3'd3,
      CSR_DEPTH_MODE = 3'd4
   } csr_idx_type;

   typedef enum logic [1:0] {
      PH_BLUE  = 2'd0,
      PH_GREEN = 2'd1,
      PH_RED   = 2'd2
   } phase_type;

   typedef struct packed {
      logic               status;
      logic               use_palette;
      logic [COLOR_W-1:0] color;
      logic [ROW_W-1:0]   row_inv;
      logic [COL_W-1:0]   col;
      logic [DIM_W-1:0]   width;
      logic               last;
   } stage_a_type;

endpackage

`default_nettype wire

@@ src/bpd_palette.sv @@
// Palette RAM: one write and one registered read per cycle.
`default_nettype none

module bpd_palette import bpd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               wr_en,
   input  wire logic [BYTE_W-1:0]  wr_idx,
   input  wire logic [COLOR_W-1:0] wr_data,
   input  wire logic               rd_en,
   input  wire logic [BYTE_W-1:0]  rd_idx,
   output logic      [COLOR_W-1:0] rd_data
);

   logic [COLOR_W-1:0] mem [PALETTE_ENTRIES];
   logic [COLOR_W-1:0] rd_ff;
   logic               rd_ok_ff;
   logic               wr_ok;
   logic               rd_ok;

   assign wr_ok = {1'b0, wr_idx} < (BYTE_W + 1)'(PALETTE_ENTRIES);
   assign rd_ok = {1'b0, rd_idx} < (BYTE_W + 1)'(PALETTE_ENTRIES);

   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem[wr_idx[PAL_IDX_W-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff    <= mem[rd_idx[PAL_IDX_W-1:0]];
         rd_ok_ff <= rd_ok;
      end
   end

   // out-of-range lookups read as black
   assign rd_data = rd_ok_ff ? rd_ff : '0;

endmodule

`default_nettype wire

@@ src/bpd_byte_ctrl.sv @@
// Configuration registers, row/byte counters and the first pipeline stage.
`default_nettype none

module bpd_byte_ctrl import bpd_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wen,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [DIM_W-1:0]     csr_wdata,
   input  wire logic                 accept,
   input  wire logic                 op,
   input  wire logic [BYTE_W-1:0]    data_byte,
   input  wire logic                 stage_free,
   output logic                      a_vld,
   output stage_a_type               a_data
);

   logic [DIM_W-1:0]  exp_w_ff, exp_w_in;
   logic [DIM_W-1:0]  exp_h_ff, exp_h_in;
   logic [DIM_W-1:0]  img_w_ff, img_w_in;
   logic [DIM_W-1:0]  img_h_ff, img_h_in;
   logic              depth_ff, depth_in;
   logic [RUN_W-1:0]  byte_ff, byte_in;
   phase_type         phase_ff, phase_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [BYTE_W-1:0] held_blue_ff, held_blue_in;
   logic [BYTE_W-1:0] held_green_ff, held_green_in;
   logic              a_vld_ff, a_vld_in;
   stage_a_type       a_data_ff, a_data_in;

   logic              size_bad;
   logic              mode24;
   logic [LIM_W-1:0]  width3;
   logic [RUN_W-1:0]  active_len;
   logic [RUN_W:0]    len_round;
   logic [RUN_W:0]    row_len;
   logic [RUN_W:0]    byte_inc;
   logic [ROW_W:0]    row_inc;
   logic              in_active;
   logic              row_end;
   logic              emit;
   logic [COL_W-1:0]  col_now;
   logic [DIM_W-1:0]  row_inv_full;
   logic              last_now;
   logic              pixel_item;

   always_comb begin
      size_bad = (exp_w_ff != img_w_ff) || (exp_h_ff != img_h_ff)
              || (img_w_ff == '0) || (img_h_ff == '0)
              || (LIM_W'(img_w_ff) > LIM_W'(MAX_WIDTH))
              || (LIM_W'(img_h_ff) > LIM_W'(MAX_HEIGHT));
      mode24     = (depth_ff == DEPTH_24BPP);
      width3     = (LIM_W'(img_w_ff) << 1) + LIM_W'(img_w_ff);
      active_len = mode24 ? width3[RUN_W-1:0] : RUN_W'(img_w_ff);
      // round the row up to whole 32-bit words
      len_round  = {1'b0, active_len} + (RUN_W + 1)'(3);
      row_len    = {len_round[RUN_W:2], 2'b00};
      byte_inc   = {1'b0, byte_ff} + (RUN_W + 1)'(1);
      row_inc    = {1'b0, row_ff} + (ROW_W + 1)'(1);
      in_active  = byte_ff < active_len;
      row_end    = byte_inc >= row_len;
      emit       = in_active && (!mode24 || (phase_ff == PH_RED));
      col_now    = mode24 ? col_ff : byte_ff[COL_W-1:0];
      row_inv_full = img_h_ff - DIM_W'(1) - DIM_W'(row_ff);
      last_now   = (DIM_W'(row_ff) == (img_h_ff - DIM_W'(1)))
                && (DIM_W'(col_now) == (img_w_ff - DIM_W'(1)));
      pixel_item = accept && (op == OP_PIXEL);
   end

   always_comb begin
      exp_w_in      = exp_w_ff;
      exp_h_in      = exp_h_ff;
      img_w_in      = img_w_ff;
      img_h_in      = img_h_ff;
      depth_in      = depth_ff;
      byte_in       = byte_ff;
      phase_in      = phase_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      held_blue_in  = held_blue_ff;
      held_green_in = held_green_ff;
      a_vld_in      = a_vld_ff && !stage_free;
      a_data_in     = a_data_ff;

      if (csr_wen) begin
         unique case (csr_idx_type'(csr_index))
            CSR_EXP_WIDTH:  exp_w_in = csr_wdata;
            CSR_EXP_HEIGHT: exp_h_in = csr_wdata;
            CSR_IMG_WIDTH:  img_w_in = csr_wdata;
            CSR_IMG_HEIGHT: img_h_in = csr_wdata;
            CSR_DEPTH_MODE: depth_in = csr_wdata[0];
            default: ;
         endcase
         // any known register restarts the image
         if (csr_index <= CSR_IDX_W'(CSR_DEPTH_MODE)) begin
            byte_in       = '0;
            phase_in      = PH_BLUE;
            col_in        = '0;
            row_in        = '0;
            held_blue_in  = '0;
            held_green_in = '0;
         end
      end else if (pixel_item) begin
         if (size_bad) begin
            a_vld_in         = 1'b1;
            a_data_in        = '0;
            a_data_in.status = STATUS_SIZE_ERR;
         end else begin
            a_vld_in              = emit;
            a_data_in.status      = STATUS_OK;
            a_data_in.use_palette = !mode24;
            a_data_in.color       = {held_blue_ff, held_green_ff, data_byte};
            a_data_in.row_inv     = row_inv_full[ROW_W-1:0];
            a_data_in.col         = col_now;
            a_data_in.width       = img_w_ff;
            a_data_in.last        = last_now;

            if (in_active && mode24) begin
               unique case (phase_ff)
                  PH_BLUE: begin
                     held_blue_in = data_byte;
                     phase_in     = PH_GREEN;
                  end
                  PH_GREEN: begin
                     held_green_in = data_byte;
                     phase_in      = PH_RED;
                  end
                  PH_RED: begin
                     phase_in = PH_BLUE;
                     col_in   = col_ff + COL_W'(1);
                  end
                  default: phase_in = PH_BLUE;
               endcase
            end

            if (row_end) begin
               byte_in  = '0;
               phase_in = PH_BLUE;
               col_in   = '0;
               row_in   = (LIM_W'(row_inc) >= LIM_W'(img_h_ff)) ? '0 : row_inc[ROW_W-1:0];
            end else begin
               byte_in = byte_inc[RUN_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_w_ff      <= RST_WIDTH;
         exp_h_ff      <= RST_HEIGHT;
         img_w_ff      <= RST_WIDTH;
         img_h_ff      <= RST_HEIGHT;
         depth_ff      <= DEPTH_8BPP;
         byte_ff       <= '0;
         phase_ff      <= PH_BLUE;
         col_ff        <= '0;
         row_ff        <= '0;
         held_blue_ff  <= '0;
         held_green_ff <= '0;
         a_vld_ff      <= 1'b0;
      end else begin
         exp_w_ff      <= exp_w_in;
         exp_h_ff      <= exp_h_in;
         img_w_ff      <= img_w_in;
         img_h_ff      <= img_h_in;
         depth_ff      <= depth_in;
         byte_ff       <= byte_in;
         phase_ff      <= phase_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         held_blue_ff  <= held_blue_in;
         held_green_ff <= held_green_in;
         a_vld_ff      <= a_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      a_data_ff <= a_data_in;
   end

   assign a_vld  = a_vld_ff;
   assign a_data = a_data_ff;

   a_row_in_image: assert property (@(posedge clock) disable iff (reset)
      !size_bad |-> (LIM_W'(row_ff) < LIM_W'(img_h_ff)))
      else $error("row counter beyond image height");

   a_byte_in_row: assert property (@(posedge clock) disable iff (reset)
      !size_bad |-> ({1'b0, byte_ff} < row_len))
      else $error("byte counter beyond padded row length");

   a_8bpp_idle_triple: assert property (@(posedge clock) disable iff (reset)
      !mode24 |-> ((phase_ff == PH_BLUE) && (col_ff == '0)))
      else $error("triple tracking moved in 8bpp mode");

endmodule

`default_nettype wire

@@ src/bpd_pixel_out.sv @@
// Address multiply, colour select and the result register.
`default_nettype none

module bpd_pixel_out import bpd_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   a_vld,
   input  wire stage_a_type            a_data,
   input  wire logic [COLOR_W-1:0]     pal_rd,
   output logic                        stage_free,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [OUT_TDATA_W-1:0] rsp_tdata,
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   logic               out_vld_ff, out_vld_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic               status_ff, status_in;
   logic               last_ff, last_in;
   logic [PROD_W-1:0]  row_base;
   logic [PROD_W-1:0]  addr_sum;
   logic               is_err;

   assign stage_free = !out_vld_ff || rsp_tready;

   always_comb begin
      row_base = PROD_W'(a_data.row_inv) * PROD_W'(a_data.width);
      addr_sum = row_base + PROD_W'(a_data.col);
      is_err   = (a_data.status == STATUS_SIZE_ERR);

      out_vld_in = out_vld_ff;
      addr_in    = addr_ff;
      color_in   = color_ff;
      status_in  = status_ff;
      last_in    = last_ff;
      if (stage_free) begin
         out_vld_in = a_vld;
         if (a_vld) begin
            // a size error carries zeros in every field but status
            addr_in   = is_err ? '0 : addr_sum[ADDR_W-1:0];
            color_in  = is_err ? '0 : (a_data.use_palette ? pal_rd : a_data.color);
            status_in = a_data.status;
            last_in   = is_err ? 1'b0 : a_data.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      color_ff  <= color_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{OUT_PAD_W{1'b0}}, color_ff, addr_ff};
   assign rsp_tuser  = status_ff;
   assign rsp_tlast  = last_ff;

   a_error_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && (status_ff == STATUS_SIZE_ERR))
         |-> ((addr_ff == '0) && (color_ff == '0) && !last_ff))
      else $error("size error transaction carries pixel data");

endmodule

`default_nettype wire

@@ src/bmp_pixel_decoder_unit.sv @@
// Top level of the BMP 8bpp/24bpp pixel decoder.
`default_nettype none

// Accepts one transaction per clock unless the result side stalls: either a palette
// load or one raw pixel-data byte, rows bottom-up and padded to 4 bytes. Each 8bpp
// byte, or each completed B,G,R triple in 24bpp mode, yields one pixel at the
// vertically flipped address; padding bytes and palette loads yield nothing. A result
// passes first through the registered palette RAM read and counter update, then
// through the address multiply into the result register. The rate of one byte per
// cycle is set by the palette read and the row/byte counters.
// The palette is not cleared at reset; read only entries that have been loaded. When
// the header size disagrees with the expected size, or is zero or beyond 1024, every
// data byte returns status 1. Write configuration only while no transaction is in
// flight; any write to a known register restarts the image.
module bmp_pixel_decoder_unit import bpd_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wen,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [DIM_W-1:0]       csr_wdata,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // palette_index[7:0], entry_blue[15:8], entry_green[23:16], entry_red[31:24],
   // data_byte[39:32]
   input  wire logic [IN_TDATA_W-1:0]  req_tdata,
   // op
   input  wire logic                   req_tuser,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // pixel_address[19:0], pixel_color[43:20], zero[47:44]
   output logic      [OUT_TDATA_W-1:0] rsp_tdata,
   // status
   output logic                        rsp_tuser,
   // last_pixel
   output logic                        rsp_tlast
);

   logic [BYTE_W-1:0]  palette_index;
   logic [BYTE_W-1:0]  entry_blue;
   logic [BYTE_W-1:0]  entry_green;
   logic [BYTE_W-1:0]  entry_red;
   logic [BYTE_W-1:0]  data_byte;
   logic               accept;
   logic               a_vld;
   stage_a_type        a_data;
   logic               stage_free;
   logic [COLOR_W-1:0] pal_rd;

   assign palette_index = req_tdata[7:0];
   assign entry_blue    = req_tdata[15:8];
   assign entry_green   = req_tdata[23:16];
   assign entry_red     = req_tdata[31:24];
   assign data_byte     = req_tdata[39:32];

   // take a new byte whenever the first stage is empty or moving on
   assign req_tready = !a_vld || stage_free;
   assign accept     = req_tvalid && req_tready;

   bpd_palette u_palette (
      .clock   (clock),
      .wr_en   (accept && (req_tuser == OP_PALETTE)),
      .wr_idx  (palette_index),
      .wr_data ({entry_blue, entry_green, entry_red}),
      .rd_en   (accept && (req_tuser == OP_PIXEL)),
      .rd_idx  (data_byte),
      .rd_data (pal_rd)
   );

   bpd_byte_ctrl u_byte_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .op         (req_tuser),
      .data_byte  (data_byte),
      .stage_free (stage_free),
      .a_vld      (a_vld),
      .a_data     (a_data)
   );

   bpd_pixel_out u_pixel_out (
      .clock      (clock),
      .reset      (reset),
      .a_vld      (a_vld),
      .a_data     (a_data),
      .pal_rd     (pal_rd),
      .stage_free (stage_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
